// ===== hdl/wft_pkg.sv =====
// Package for the word frequency table: sizes, mode codes and shared types.
// No dependencies.
package wft_pkg;
    localparam int MaxEntries = 256;
    localparam int MaxWordLen = 255;
    localparam int SlotW = $clog2(MaxEntries);
    localparam int CntW = 24;
    localparam int LenW = 8;
    localparam int UsedW = SlotW + 1;
    localparam int ByteAddrW = SlotW + 8;
    localparam logic [CntW-1:0] CountTop = {CntW{1'b1}};
    localparam logic [1:0] ModeByte = 2'd0;
    localparam logic [1:0] ModeFlush = 2'd1;
    localparam logic [1:0] ModeRead = 2'd2;

    typedef struct packed {
        logic [7:0]      slot;
        logic [CntW-1:0] count;
        logic            fresh;
        logic            drop;
        logic [LenW-1:0] len;
        logic [8:0]      used;
    } t_result;
endpackage

// ===== hdl/wft_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wft_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/word_frequency_table.sv =====
// Word frequency table top level: byte-serial sequencer, one shared byte
// comparator over entry and pending-word RAMs. Uses wft_pkg and wft_ram.
//
// Input channel (i_valid/o_stall): one beat per byte, flush or read.
// Output channel (o_valid/i_stall): at most one result beat per input beat.
// A plain word byte is appended to the pending word. A completed word is
// compared against each stored entry in insertion order, one byte at a
// time through a single comparator: an entry of another length is skipped
// after its length check, an entry of equal length is compared byte by
// byte, and a full match then updates the count. A new word is then copied
// into its row byte by byte. Latency is thus set by the compare loop.
// o_stall is high while an item is at work and while a result waits; a
// stalled result holds steady. Reset clears the entry count and the pending
// length; the RAMs need no clearing.
module word_frequency_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_text_byte,
    input  logic [7:0]  i_entry_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_entry_slot,
    output logic [23:0] o_occurrences,
    output logic        o_new_word,
    output logic        o_dropped,
    output logic [7:0]  o_word_length,
    output logic [8:0]  o_unique_words
);
    import wft_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_APPEND = 4'd1, S_LEN = 4'd2,
        S_LENCHK = 4'd3, S_CMP = 4'd4, S_CMPCHK = 4'd5, S_COPY = 4'd6,
        S_COPYW = 4'd7, S_RD = 4'd8, S_RDW = 4'd9, S_HIT = 4'd10,
        S_HITW = 4'd11, S_OUT = 4'd12;

    logic [3:0]       r_state, n_state;
    logic [UsedW-1:0] r_used, n_used;
    logic [7:0]       r_plen, n_plen;
    logic [SlotW-1:0] r_slot, n_slot;
    logic [7:0]       r_pos, n_pos;
    logic [7:0]       r_byte, n_byte;
    logic [7:0]       r_idx, n_idx;
    logic             r_rdok, n_rdok;
    t_result          r_res, n_res;

    logic             len_we, cnt_we, wb_we, pb_we;
    logic [SlotW-1:0] len_ra, cnt_ra, meta_wa;
    logic [LenW-1:0]  len_rd;
    logic [CntW-1:0]  cnt_rd, cnt_wd;
    logic [ByteAddrW-1:0] wb_wa, wb_ra;
    logic [7:0]       wb_rd, pb_wa, pb_ra, pb_rd, pb_wd;

    wft_ram #(.Width(LenW), .Depth(MaxEntries)) u_len (
        .i_clk(i_clk), .i_we(len_we), .i_waddr(meta_wa), .i_wdata(r_plen),
        .i_raddr(len_ra), .o_rdata(len_rd));
    wft_ram #(.Width(CntW), .Depth(MaxEntries)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(meta_wa), .i_wdata(cnt_wd),
        .i_raddr(cnt_ra), .o_rdata(cnt_rd));
    wft_ram #(.Width(8), .Depth(MaxEntries * 256)) u_wb (
        .i_clk(i_clk), .i_we(wb_we), .i_waddr(wb_wa), .i_wdata(pb_rd),
        .i_raddr(wb_ra), .o_rdata(wb_rd));
    wft_ram #(.Width(8), .Depth(256)) u_pb (
        .i_clk(i_clk), .i_we(pb_we), .i_waddr(pb_wa), .i_wdata(pb_wd),
        .i_raddr(pb_ra), .o_rdata(pb_rd));

    logic accept, sep;
    assign accept = i_valid && !o_stall;
    assign sep = (i_text_byte == 8'd32) || (i_text_byte inside {[8'd9:8'd13]});
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state; n_used = r_used; n_plen = r_plen; n_slot = r_slot;
        n_pos = r_pos; n_byte = r_byte; n_idx = r_idx; n_rdok = r_rdok;
        n_res = r_res;
        len_we = 1'b0; cnt_we = 1'b0; wb_we = 1'b0; pb_we = 1'b0;
        len_ra = r_slot; cnt_ra = r_slot; meta_wa = r_slot; cnt_wd = '0;
        wb_ra = {r_slot, r_pos}; wb_wa = {r_slot, r_pos - 8'd1};
        pb_wa = r_plen; pb_wd = r_byte; pb_ra = r_pos;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_byte = i_text_byte; n_idx = i_entry_index;
                    n_slot = '0; n_pos = '0;
                    case (i_mode)
                        ModeByte: begin
                            if (sep) begin
                                if (r_plen != 8'd0) n_state = S_LEN;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end
                        ModeFlush: if (r_plen != 8'd0) n_state = S_LEN;
                        ModeRead: begin
                            n_rdok = ({1'b0, i_entry_index} < 9'(r_used));
                            n_slot = i_entry_index[SlotW-1:0];
                            n_state = S_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_APPEND: begin
                pb_we = 1'b1;
                n_plen = r_plen + 8'd1;
                n_state = (r_plen == 8'(MaxWordLen - 1)) ? S_LEN : S_IDLE;
            end
            S_LEN: begin
                if ({1'b0, r_slot} >= r_used) begin
                    if (r_used >= UsedW'(MaxEntries)) begin
                        n_res = '{slot: '0, count: '0, fresh: 1'b0, drop: 1'b1,
                                  len: r_plen, used: 9'(r_used)};
                        n_plen = '0;
                        n_state = S_OUT;
                    end else begin
                        n_pos = '0;
                        n_state = S_COPY;
                    end
                end else begin
                    n_state = S_LENCHK;
                end
            end
            S_LENCHK: begin
                if (len_rd == r_plen) begin
                    n_pos = '0; n_state = S_CMP;
                end else begin
                    n_slot = r_slot + SlotW'(1);
                    if (r_slot == SlotW'(MaxEntries - 1)) n_slot = r_slot;
                    n_state = (r_slot == SlotW'(MaxEntries - 1)) ? S_LEN : S_LEN;
                    if (r_slot == SlotW'(MaxEntries - 1)) begin
                        n_res = '{slot: '0, count: '0, fresh: 1'b0, drop: 1'b1,
                                  len: r_plen, used: 9'(r_used)};
                        n_plen = '0;
                        n_state = S_OUT;
                    end
                end
            end
            S_CMP: begin
                if (r_pos == r_plen) begin
                    n_state = S_HIT;
                end else begin
                    n_state = S_CMPCHK;
                end
            end
            S_CMPCHK: begin
                if (wb_rd == pb_rd) begin
                    n_pos = r_pos + 8'd1;
                    n_state = S_CMP;
                end else begin
                    n_slot = r_slot + SlotW'(1);
                    if (r_slot == SlotW'(MaxEntries - 1)) begin
                        n_res = '{slot: '0, count: '0, fresh: 1'b0, drop: 1'b1,
                                  len: r_plen, used: 9'(r_used)};
                        n_plen = '0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_LEN;
                    end
                end
                pb_ra = r_pos;
            end
            S_HIT: n_state = S_HITW;
            S_HITW: begin
                cnt_wd = (cnt_rd == CountTop) ? cnt_rd : cnt_rd + CntW'(1);
                cnt_we = 1'b1;
                n_res = '{slot: 8'(r_slot), count: cnt_wd, fresh: 1'b0, drop: 1'b0,
                          len: r_plen, used: 9'(r_used)};
                n_plen = '0;
                n_state = S_OUT;
            end
            S_COPY: begin
                n_pos = r_pos + 8'd1;
                n_state = S_COPYW;
            end
            S_COPYW: begin
                wb_we = 1'b1;
                if (r_pos == r_plen) begin
                    len_we = 1'b1; cnt_we = 1'b1; cnt_wd = CntW'(1);
                    n_used = r_used + UsedW'(1);
                    n_res = '{slot: 8'(r_slot), count: CntW'(1), fresh: 1'b1,
                              drop: 1'b0, len: r_plen, used: 9'(r_used + UsedW'(1))};
                    n_plen = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_COPY;
                end
            end
            S_RD: n_state = S_RDW;
            S_RDW: begin
                n_res = '{slot: r_idx, count: r_rdok ? cnt_rd : '0, fresh: 1'b0,
                          drop: 1'b0, len: r_rdok ? len_rd : '0, used: 9'(r_used)};
                n_state = S_OUT;
            end
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_used <= '0; r_plen <= '0;
        end else begin
            r_state <= n_state; r_used <= n_used; r_plen <= n_plen;
        end
        r_slot <= n_slot; r_pos <= n_pos; r_byte <= n_byte; r_idx <= n_idx;
        r_rdok <= n_rdok; r_res <= n_res;
    end

    assign o_entry_slot = r_res.slot;
    assign o_occurrences = r_res.count;
    assign o_new_word = r_res.fresh;
    assign o_dropped = r_res.drop;
    assign o_word_length = r_res.len;
    assign o_unique_words = r_res.used;

    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UsedW'(MaxEntries)) else $error("entry count overflow");
    a_plen_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= 8'(MaxWordLen)) else $error("pending length overflow");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_new_word && o_dropped)) else $error("new and dropped");
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used != $past(r_used) |-> r_used == $past(r_used) + UsedW'(1))
        else $error("entry count jump");
endmodule
